// File: rtl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// Shared types, constants and the 6-and-2 write table for the GCR sector
// encoder.
// ----------------------------------------------------------------------------
package gse_pkg;

  // Sector geometry
  localparam int unsigned SECTOR_BYTES = 524;
  localparam int unsigned POS_W        = 10;

  // Byte phase within a group of three
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // Kind of work handed from front to back
  typedef enum logic {
    JOB_GROUP = 1'b0,   // full group: four disk bytes
    JOB_LAST  = 1'b1    // short last group plus checksum: seven disk bytes
  } job_kind_t;

  // One queued group of whitened bytes, plus the checksum for the last one
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] ck_c;
  } job_t;

  // Disk byte slot within a job
  typedef enum logic [2:0] {
    NIB_TWOS   = 3'd0,
    NIB_FIRST  = 3'd1,
    NIB_SECOND = 3'd2,
    NIB_FOURTH = 3'd3,  // third byte, or checksum twos on the last job
    NIB_CK_C   = 3'd4,
    NIB_CK_B   = 3'd5,
    NIB_CK_A   = 3'd6
  } nib_t;

  // 6-and-2 write translate table
  localparam logic [7:0] GCR_WRITE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

endpackage

// File: rtl/gse_front.sv
// ----------------------------------------------------------------------------
// gse_front
// Accepts sector bytes, runs the three rotating checksums, whitens each byte
// and hands completed groups to the job queue.
// ----------------------------------------------------------------------------
module gse_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              q_push,
  output gse_pkg::job_t     q_job
);

  logic [gse_pkg::POS_W-1:0] pos_r, pos_nxt;
  gse_pkg::phase_t           phase_r, phase_nxt;
  logic [8:0]                sum_a_r, sum_a_nxt;
  logic [8:0]                sum_b_r, sum_b_nxt;
  logic [8:0]                sum_c_r, sum_c_nxt;
  logic [7:0]                first_r, first_nxt;
  logic [7:0]                second_r, second_nxt;
  logic [7:0]                third;
  logic                      accept;
  logic                      last_byte;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign last_byte = (pos_r == gse_pkg::POS_W'(gse_pkg::SECTOR_BYTES - 1));

  // Update checksums and whiten the incoming byte by phase
  always_comb begin
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    sum_c_nxt  = sum_c_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    third      = in_data_byte ^ sum_b_r[7:0];
    case (phase_r)
      gse_pkg::PH_FIRST: begin
        // rotate sum_a left, carry out feeds sum_c
        sum_a_nxt = {1'b0, sum_a_r[6:0], sum_a_r[7]};
        sum_c_nxt = sum_c_r + {1'b0, in_data_byte} + {8'd0, sum_a_r[7]};
        first_nxt = in_data_byte ^ {sum_a_r[6:0], sum_a_r[7]};
      end
      gse_pkg::PH_SECOND: begin
        sum_b_nxt  = sum_b_r + {1'b0, in_data_byte} + {8'd0, sum_c_r[8]};
        sum_c_nxt  = {1'b0, sum_c_r[7:0]};
        second_nxt = in_data_byte ^ sum_c_r[7:0];
      end
      gse_pkg::PH_THIRD: begin
        sum_a_nxt = sum_a_r + {1'b0, in_data_byte} + {8'd0, sum_b_r[8]};
        sum_b_nxt = {1'b0, sum_b_r[7:0]};
      end
      default: begin
        sum_a_nxt = sum_a_r;
      end
    endcase
  end

  // Build the job for a completed group or the end of the sector
  always_comb begin
    q_push      = accept && (phase_r == gse_pkg::PH_THIRD || last_byte);
    q_job.kind  = last_byte ? gse_pkg::JOB_LAST : gse_pkg::JOB_GROUP;
    q_job.first = first_r;
    q_job.second = last_byte ? second_nxt : second_r;
    q_job.third = last_byte ? 8'd0 : third;
    q_job.ck_a  = sum_a_nxt[7:0];
    q_job.ck_b  = sum_b_nxt[7:0];
    q_job.ck_c  = sum_c_nxt[7:0];
  end

  // Advance position and phase, wrap at end of sector
  always_comb begin
    if (last_byte) begin
      pos_nxt   = '0;
      phase_nxt = gse_pkg::PH_FIRST;
    end else begin
      pos_nxt   = pos_r + gse_pkg::POS_W'(1);
      case (phase_r)
        gse_pkg::PH_FIRST:  phase_nxt = gse_pkg::PH_SECOND;
        gse_pkg::PH_SECOND: phase_nxt = gse_pkg::PH_THIRD;
        default:            phase_nxt = gse_pkg::PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= gse_pkg::PH_FIRST;
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_c_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      if (last_byte) begin
        sum_a_r <= '0;
        sum_b_r <= '0;
        sum_c_r <= '0;
      end else begin
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
        sum_c_r <= sum_c_nxt;
      end
    end
  end

  // Held whitened bytes of the current group
  always_ff @(posedge clk) begin
    if (accept) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// File: rtl/gse_queue.sv
// ----------------------------------------------------------------------------
// gse_queue
// Two-entry job queue between the checksum front and the disk byte back.
// ----------------------------------------------------------------------------
module gse_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gse_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output gse_pkg::job_t head_job
);

  gse_pkg::job_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/gse_back.sv
// ----------------------------------------------------------------------------
// gse_back
// Walks each queued job nibble by nibble, maps it through the write table and
// presents one disk byte per cycle in the output register while a job is queued and out_ready does not hold it.
// ----------------------------------------------------------------------------
module gse_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  gse_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_disk_byte,
  output logic          out_run_end,
  output logic          out_sector_end
);

  gse_pkg::nib_t nib_r, nib_nxt;
  logic          out_valid_r;
  logic [7:0]    disk_byte_r;
  logic          run_end_r;
  logic          sector_end_r;
  logic          load;
  logic          last_nib;
  logic [5:0]    six;

  assign out_valid      = out_valid_r;
  assign out_disk_byte  = disk_byte_r;
  assign out_run_end    = run_end_r;
  assign out_sector_end = sector_end_r;

  assign load     = head_valid && (!out_valid_r || out_ready);
  assign last_nib = (head_job.kind == gse_pkg::JOB_LAST) ? (nib_r == gse_pkg::NIB_CK_A)
                                                         : (nib_r == gse_pkg::NIB_FOURTH);
  assign pop      = load && last_nib;

  // Select the six-bit value for the current slot
  always_comb begin
    case (nib_r)
      gse_pkg::NIB_TWOS:
        six = {head_job.first[7:6], head_job.second[7:6], head_job.third[7:6]};
      gse_pkg::NIB_FIRST:  six = head_job.first[5:0];
      gse_pkg::NIB_SECOND: six = head_job.second[5:0];
      gse_pkg::NIB_FOURTH: begin
        if (head_job.kind == gse_pkg::JOB_LAST) begin
          six = {head_job.ck_c[7:6], head_job.ck_b[7:6], head_job.ck_a[7:6]};
        end else begin
          six = head_job.third[5:0];
        end
      end
      gse_pkg::NIB_CK_C:   six = head_job.ck_c[5:0];
      gse_pkg::NIB_CK_B:   six = head_job.ck_b[5:0];
      gse_pkg::NIB_CK_A:   six = head_job.ck_a[5:0];
      default:             six = '0;
    endcase
  end

  // Step to the next slot, restart after the job's last one
  always_comb begin
    if (last_nib) begin
      nib_nxt = gse_pkg::NIB_TWOS;
    end else begin
      nib_nxt = gse_pkg::nib_t'(nib_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nib_r       <= gse_pkg::NIB_TWOS;
      out_valid_r <= 1'b0;
    end else if (load) begin
      nib_r       <= nib_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      disk_byte_r  <= gse_pkg::GCR_WRITE[six];
      run_end_r    <= last_nib;
      sector_end_r <= last_nib && (head_job.kind == gse_pkg::JOB_LAST);
    end
  end

endmodule

// File: rtl/gcr_sector_encoder_524_top.sv
// A completed group is queued; its first disk byte then goes to the output register.
// Throughput: one disk byte per cycle while a job is queued and out_ready allows it;
//   a group of three bytes gives four disk bytes and the sector's last group seven.
// Input bytes are taken every cycle while the two-entry job queue has room.
// Reset (synchronous, rst_n low) clears position, checksums, queue and output valid.
// ----------------------------------------------------------------------------
// gcr_sector_encoder_524_top
// 524-byte sector encoder: checksum and whitening front, job queue, and a
// 6-and-2 disk byte back end.
// ----------------------------------------------------------------------------
module gcr_sector_encoder_524_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_disk_byte,
  output logic       out_run_end,
  output logic       out_sector_end
);

  logic          q_full;
  logic          q_push;
  gse_pkg::job_t q_push_job;
  logic          q_pop;
  logic          q_head_valid;
  gse_pkg::job_t q_head_job;

  // Front: checksums, whitening, group classification
  gse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_push_job)
  );

  // Job queue
  gse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Back: nibble sequencing and table lookup
  gse_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_job       (q_head_job),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_disk_byte  (out_disk_byte),
    .out_run_end    (out_run_end),
    .out_sector_end (out_sector_end)
  );

endmodule
